// ===== design/clp_pkg.sv =====
// ----------------------------------------------------------------------------
// clp_pkg
// Types, constants and codes shared by the core load thread placer.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int NUM_CORES = 16;
  localparam int CORE_W    = 4;
  localparam int IDX_W     = CORE_W + 1;
  localparam int PCT_W     = 7;
  localparam int NUM_W     = 72;
  localparam int DEN_W     = 66;
  localparam int PCT_SCALE = 100;
  localparam int LIMB_W    = 8;
  localparam int NUM_LIMBS = NUM_W / LIMB_W;
  localparam int RECIP_SH  = 19;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SH for x below 100 * 2^LIMB_W
  localparam logic [12:0] RECIP_100 = 13'd5243;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_IDLE   = 2'd1;
  localparam logic [1:0] FUNC_ACTIVE = 2'd2;
  localparam logic [1:0] FUNC_FINISH = 2'd3;

  localparam logic [1:0] FA_NONE      = 2'd0;
  localparam logic [1:0] FA_SET_MAX   = 2'd1;
  localparam logic [1:0] FA_STEP_UP   = 2'd2;
  localparam logic [1:0] FA_STEP_DOWN = 2'd3;

  localparam logic [1:0] CFG_LOAD_LIMIT = 2'd0;
  localparam logic [1:0] CFG_CORE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_CORE_BUSY  = 2'd2;
  localparam logic [1:0] CFG_MAIN_CORE  = 2'd3;

  localparam logic DIV_PCT   = 1'b0;
  localparam logic DIV_CLAMP = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  core_index;
    logic [63:0] busy_ticks;
    logic [63:0] idle_ticks;
    logic [15:0] thread_total;
    logic [15:0] allowed_cores;
  } in_t;

  typedef struct packed {
    logic [3:0] new_core;
    logic       moved;
    logic [1:0] freq_action;
  } out_t;

  typedef struct packed {
    logic [6:0] thr_idle;
    logic [6:0] thr_place;
    logic [6:0] thr_clamp;
    logic [3:0] home_core;
  } cfg_t;

  typedef struct packed {
    in_t  item;
    logic in_range;
  } q_item_t;

endpackage

// ===== design/clp_div.sv =====
// ----------------------------------------------------------------------------
// clp_div
// Percentage by restoring division, one quotient bit per cycle; divide by 100
// one byte per cycle by reciprocal multiplication.
// ----------------------------------------------------------------------------
module clp_div import clp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             mode_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] q_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [6:0]              cnt_q, cnt_d;
  logic                    zero_q, zero_d;
  logic                    mode_q, mode_d;
  logic [DEN_W-1:0]        den_q, den_d;
  logic [DEN_W-1:0]        rem_q, rem_d;
  logic [NUM_W-1:0]        dv_q, dv_d;
  logic [NUM_W-1:0]        quo_q, quo_d;
  logic [DEN_W:0]          t;
  logic [PCT_W+LIMB_W-1:0] cur;
  logic [27:0]             prod;
  logic [LIMB_W-1:0]       dq;
  logic [PCT_W+LIMB_W-1:0] dr;

  assign t    = {rem_q, dv_q[NUM_W-1]};
  assign cur  = {rem_q[PCT_W-1:0], dv_q[NUM_W-1 -: LIMB_W]};
  assign prod = 28'(cur) * 28'(RECIP_100);
  assign dq   = prod[RECIP_SH +: LIMB_W];
  assign dr   = cur - (PCT_W+LIMB_W)'(dq) * (PCT_W+LIMB_W)'(PCT_SCALE);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    zero_d = zero_q;
    mode_d = mode_q;
    den_d  = den_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      zero_d = (den_i == '0);
      mode_d = mode_i;
      den_d  = den_i;
      quo_d  = '0;
      if (mode_i == DIV_PCT) begin
        rem_d = DEN_W'(num_i >> PCT_W);
        dv_d  = {num_i[PCT_W-1:0], {(NUM_W-PCT_W){1'b0}}};
        cnt_d = 7'(PCT_W);
      end else begin
        rem_d = '0;
        dv_d  = num_i;
        cnt_d = 7'(NUM_LIMBS);
      end
    end else if (busy_q) begin
      if (mode_q == DIV_CLAMP) begin
        rem_d = DEN_W'(dr[PCT_W-1:0]);
        quo_d = {quo_q[NUM_W-LIMB_W-1:0], dq};
        dv_d  = {dv_q[NUM_W-LIMB_W-1:0], {LIMB_W{1'b0}}};
      end else begin
        if (t >= {1'b0, den_q}) begin
          rem_d = DEN_W'(t - {1'b0, den_q});
          quo_d = {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = t[DEN_W-1:0];
          quo_d = {quo_q[NUM_W-2:0], 1'b0};
        end
        dv_d = {dv_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      zero_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign q_o    = zero_q ? '0 : quo_q;

endmodule

// ===== design/clp_front.sv =====
// ----------------------------------------------------------------------------
// clp_front
// Takes commands, marks the core index range, and queues them for the back end.
// ----------------------------------------------------------------------------
module clp_front import clp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  in_t     cmd_i,
  output logic    busy_o,
  output logic    valid_o,
  output q_item_t item_o,
  input  logic    pop_i
);

  q_item_t    ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  q_item_t    new_item;

  assign push = start_i && !busy_o;
  assign new_item.item = cmd_i;
  assign new_item.in_range = ({1'b0, cmd_i.core_index} < IDX_W'(NUM_CORES));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_item;
    end
  end

  assign busy_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = ent_q[rd_ptr_q];

endmodule

// ===== design/clp_back.sv =====
// ----------------------------------------------------------------------------
// clp_back
// Sequencer: core stats store, placement search, moves, frequency action.
// ----------------------------------------------------------------------------
module clp_back import clp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  q_item_t item_i,
  output logic    pop_o,
  output logic    done_o,
  output out_t    res_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CALL   = 5'd1;
  localparam logic [4:0] S_WAIT   = 5'd2;
  localparam logic [4:0] S_TPCT   = 5'd3;
  localparam logic [4:0] S_ALRD   = 5'd4;
  localparam logic [4:0] S_ALPCT  = 5'd5;
  localparam logic [4:0] S_FCISS  = 5'd6;
  localparam logic [4:0] S_FCRD   = 5'd7;
  localparam logic [4:0] S_FCPCT  = 5'd8;
  localparam logic [4:0] S_MOVE   = 5'd9;
  localparam logic [4:0] S_MVSRC  = 5'd10;
  localparam logic [4:0] S_MVSP   = 5'd11;
  localparam logic [4:0] S_MVDST  = 5'd12;
  localparam logic [4:0] S_MVNP   = 5'd13;
  localparam logic [4:0] S_MVCL   = 5'd14;
  localparam logic [4:0] S_MVWR   = 5'd15;
  localparam logic [4:0] S_FINISS = 5'd16;
  localparam logic [4:0] S_FINRD  = 5'd17;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
    return (a < b) ? '0 : a - b;
  endfunction

  logic [63:0] busy_mem [NUM_CORES];
  logic [63:0] idle_mem [NUM_CORES];
  logic [15:0] cnt_mem  [NUM_CORES];

  logic [4:0]        state_q, state_d, ret_q, ret_d;
  in_t               it_q, it_d;
  logic              lim_q, lim_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CORE_W-1:0] least_q, least_d, nc_q, nc_d;
  logic [63:0]       least_busy_q, least_busy_d;
  logic [PCT_W-1:0]  sp_q, sp_d;
  logic [63:0]       sb_q, sb_d, si_q, si_d, nsb_q, nsb_d, nsi_q, nsi_d;
  logic [15:0]       sc_q, sc_d;
  logic [64:0]       op_b_q, op_b_d, op_i_q, op_i_d;
  logic              op_mode_q, op_mode_d;
  logic              bp_q, bp_d;
  logic [63:0]       mb_q, mb_d, mi_q, mi_d;
  logic              done_q, done_d;
  out_t              res_q, res_d;

  logic [63:0]       rd_busy_q, rd_idle_q;
  logic [15:0]       rd_cnt_q;
  logic              rd_en, we;
  logic [CORE_W-1:0] rd_addr, waddr;
  logic [63:0]       w_busy, w_idle;
  logic [15:0]       w_cnt;

  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_q;
  logic [DEN_W-1:0]  div_den;

  logic [CORE_W-1:0] ci, cur_i;
  logic [63:0]       tb;
  logic              fit, take;
  logic [NUM_W-1:0]  tp;
  logic [63:0]       nb;
  logic [64:0]       diff;

  assign ci    = it_q.core_index;
  assign tb    = it_q.busy_ticks;
  assign cur_i = idx_q[CORE_W-1:0];
  assign tp    = div_q;

  assign div_num = (op_mode_q == DIV_PCT) ? NUM_W'(op_b_q) * NUM_W'(PCT_SCALE)
                                          : NUM_W'(op_b_q) * NUM_W'(cfg_i.thr_place);
  assign div_den = (op_mode_q == DIV_PCT) ? DEN_W'({1'b0, op_b_q} + {1'b0, op_i_q})
                                          : DEN_W'(PCT_SCALE);

  clp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mode_i  (op_mode_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    if (state_q == S_FCPCT) begin
      fit = (div_q < NUM_W'(cfg_i.thr_place));
    end else begin
      fit = 1'b1;
    end
    take = fit && ((cur_i == cfg_i.home_core) ||
                   ((cur_i < ci) && (ci != cfg_i.home_core)) || lim_q);
    nb   = (div_q[NUM_W-1:64] != '0) ? '1 : div_q[63:0];
    diff = op_b_q - {1'b0, nb};
  end

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    it_d         = it_q;
    lim_d        = lim_q;
    idx_d        = idx_q;
    least_d      = least_q;
    least_busy_d = least_busy_q;
    nc_d         = nc_q;
    sp_d         = sp_q;
    sb_d         = sb_q;
    si_d         = si_q;
    sc_d         = sc_q;
    nsb_d        = nsb_q;
    nsi_d        = nsi_q;
    op_b_d       = op_b_q;
    op_i_d       = op_i_q;
    op_mode_d    = op_mode_q;
    bp_d         = bp_q;
    mb_d         = mb_q;
    mi_d         = mi_q;
    done_d       = 1'b0;
    res_d        = res_q;
    pop_o        = 1'b0;
    div_start    = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = ci;
    we           = 1'b0;
    waddr        = ci;
    w_busy       = item_i.item.busy_ticks;
    w_idle       = item_i.item.idle_ticks;
    w_cnt        = item_i.item.thread_total;

    case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          it_d  = item_i.item;
          res_d = '{new_core: '0, moved: 1'b0, freq_action: FA_NONE};
          case (item_i.item.func)
            FUNC_LOAD: begin
              we     = item_i.in_range;
              waddr  = item_i.item.core_index;
              done_d = 1'b1;
            end
            FUNC_FINISH: begin
              idx_d   = '0;
              bp_d    = 1'b0;
              mb_d    = '0;
              mi_d    = '0;
              state_d = S_FINISS;
            end
            default: begin
              if (!item_i.in_range) begin
                res_d.new_core = item_i.item.core_index;
                done_d         = 1'b1;
              end else begin
                op_b_d    = {1'b0, item_i.item.busy_ticks};
                op_i_d    = {1'b0, item_i.item.idle_ticks};
                op_mode_d = DIV_PCT;
                ret_d     = S_TPCT;
                state_d   = S_CALL;
              end
            end
          endcase
        end
      end
      S_CALL: begin
        div_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          state_d = ret_q;
        end
      end
      S_TPCT: begin
        lim_d = 1'b0;
        nc_d  = ci;
        if (it_q.func == FUNC_IDLE) begin
          if ((tp < NUM_W'(cfg_i.thr_idle)) &&
              ({1'b0, cfg_i.home_core} < IDX_W'(NUM_CORES))) begin
            nc_d = cfg_i.home_core;
          end
          state_d = S_MOVE;
        end else if ((tp < NUM_W'(cfg_i.thr_idle)) || (it_q.allowed_cores == '0)) begin
          state_d = S_MOVE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ci;
          state_d = S_ALRD;
        end
      end
      S_ALRD: begin
        least_d      = ci;
        least_busy_d = rd_busy_q;
        idx_d        = '0;
        if ((rd_cnt_q <= 16'd1) || (rd_busy_q == '0)) begin
          lim_d   = 1'b0;
          state_d = S_FCISS;
        end else begin
          op_b_d    = {1'b0, rd_busy_q};
          op_i_d    = {1'b0, rd_idle_q};
          op_mode_d = DIV_PCT;
          ret_d     = S_ALPCT;
          state_d   = S_CALL;
        end
      end
      S_ALPCT: begin
        lim_d   = (div_q >= NUM_W'(cfg_i.thr_place));
        state_d = S_FCISS;
      end
      S_FCISS: begin
        if (idx_q == IDX_W'(NUM_CORES)) begin
          nc_d    = lim_q ? least_q : ci;
          state_d = S_MOVE;
        end else if (!it_q.allowed_cores[cur_i]) begin
          idx_d = idx_q + IDX_W'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_i;
          state_d = S_FCRD;
        end
      end
      S_FCRD: begin
        if (rd_busy_q < least_busy_q) begin
          least_d      = cur_i;
          least_busy_d = rd_busy_q;
        end
        if (cur_i == ci) begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_FCISS;
        end else if (((rd_busy_q == '0) && (rd_idle_q == '0)) || (rd_cnt_q == '0)) begin
          if (take) begin
            nc_d    = cur_i;
            state_d = S_MOVE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_FCISS;
          end
        end else if (rd_idle_q < tb) begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_FCISS;
        end else begin
          op_b_d    = {1'b0, rd_busy_q} + {1'b0, tb};
          op_i_d    = {1'b0, rd_idle_q - tb};
          op_mode_d = DIV_PCT;
          ret_d     = S_FCPCT;
          state_d   = S_CALL;
        end
      end
      S_FCPCT: begin
        if (take) begin
          nc_d    = cur_i;
          state_d = S_MOVE;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_FCISS;
        end
      end
      S_MOVE: begin
        if (nc_q == ci) begin
          res_d   = '{new_core: nc_q, moved: 1'b0, freq_action: FA_NONE};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ci;
          state_d = S_MVSRC;
        end
      end
      S_MVSRC: begin
        sb_d      = rd_busy_q;
        si_d      = rd_idle_q;
        sc_d      = rd_cnt_q;
        op_b_d    = {1'b0, rd_busy_q};
        op_i_d    = {1'b0, rd_idle_q};
        op_mode_d = DIV_PCT;
        ret_d     = S_MVSP;
        state_d   = S_CALL;
      end
      S_MVSP: begin
        sp_d    = div_q[PCT_W-1:0];
        rd_en   = 1'b1;
        rd_addr = nc_q;
        state_d = S_MVDST;
      end
      S_MVDST: begin
        we     = 1'b1;
        waddr  = nc_q;
        w_busy = sat_add(rd_busy_q, tb);
        w_idle = sat_sub(rd_idle_q, tb);
        w_cnt  = (rd_cnt_q != '1) ? rd_cnt_q + 16'd1 : rd_cnt_q;
        nsb_d  = sat_sub(sb_q, tb);
        nsi_d  = sat_add(si_q, tb);
        if (sp_q >= cfg_i.thr_clamp) begin
          op_b_d    = {1'b0, nsb_d};
          op_i_d    = {1'b0, nsi_d};
          op_mode_d = DIV_PCT;
          ret_d     = S_MVNP;
          state_d   = S_CALL;
        end else begin
          state_d = S_MVWR;
        end
      end
      S_MVNP: begin
        if (div_q < NUM_W'(cfg_i.thr_place)) begin
          op_b_d    = {1'b0, nsb_q} + {1'b0, nsi_q};
          op_mode_d = DIV_CLAMP;
          ret_d     = S_MVCL;
          state_d   = S_CALL;
        end else begin
          state_d = S_MVWR;
        end
      end
      S_MVCL: begin
        nsb_d = nb;
        if (op_b_q < {1'b0, nb}) begin
          nsi_d = '0;
        end else begin
          nsi_d = diff[64] ? '1 : diff[63:0];
        end
        state_d = S_MVWR;
      end
      S_MVWR: begin
        we      = 1'b1;
        waddr   = ci;
        w_busy  = nsb_q;
        w_idle  = nsi_q;
        w_cnt   = (sc_q != '0) ? sc_q - 16'd1 : sc_q;
        res_d   = '{new_core: nc_q, moved: 1'b1, freq_action: FA_NONE};
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_FINISS: begin
        if (idx_q == IDX_W'(NUM_CORES)) begin
          if (bp_q) begin
            res_d.freq_action = FA_SET_MAX;
          end else if (mb_q > mi_q) begin
            res_d.freq_action = FA_STEP_UP;
          end else begin
            res_d.freq_action = FA_STEP_DOWN;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_i;
          state_d = S_FINRD;
        end
      end
      S_FINRD: begin
        if (cur_i == cfg_i.home_core) begin
          mb_d = rd_busy_q;
          mi_d = rd_idle_q;
        end else if (rd_cnt_q != '0) begin
          bp_d = 1'b1;
        end
        idx_d   = idx_q + IDX_W'(1);
        state_d = S_FINISS;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q         <= it_d;
    lim_q        <= lim_d;
    idx_q        <= idx_d;
    least_q      <= least_d;
    least_busy_q <= least_busy_d;
    nc_q         <= nc_d;
    sp_q         <= sp_d;
    sb_q         <= sb_d;
    si_q         <= si_d;
    sc_q         <= sc_d;
    nsb_q        <= nsb_d;
    nsi_q        <= nsi_d;
    op_b_q       <= op_b_d;
    op_i_q       <= op_i_d;
    op_mode_q    <= op_mode_d;
    bp_q         <= bp_d;
    mb_q         <= mb_d;
    mi_q         <= mi_d;
    res_q        <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      busy_mem[waddr] <= w_busy;
      idle_mem[waddr] <= w_idle;
      cnt_mem[waddr]  <= w_cnt;
    end
    if (rd_en) begin
      rd_busy_q <= busy_mem[rd_addr];
      rd_idle_q <= idle_mem[rd_addr];
      rd_cnt_q  <= cnt_mem[rd_addr];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/core_load_thread_placer.sv =====
// ----------------------------------------------------------------------------
// core_load_thread_placer
// Per-period thread placement across cores with a load stats store.
//
//   port group          direction  transfer when
//   start_i/cmd_i       in         start_i high and busy_o low
//   done_o/res_o        out        done_o high (one cycle, no back-pressure)
//   cfg_we_i/idx/data   in         cfg_we_i high
//
// Load items are stored straight from idle; finish reads every core's stats.
// Thread items are bound by the shared divider, used for each percentage and
// for each clamp; an active-pass search costs up to NUM_CORES percentages.
// A two-entry command queue keeps busy_o low while the sequencer works, until full.
// Reset restores the register defaults; the core stats hold no value until loaded.
// ----------------------------------------------------------------------------
module core_load_thread_placer import clp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  in_t        cmd_i,
  output logic       busy_o,
  output logic       done_o,
  output out_t       res_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  logic    fe_valid, fe_pop;
  q_item_t fe_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOAD_LIMIT: cfg_d.thr_idle  = cfg_data_i;
        CFG_CORE_LIMIT: cfg_d.thr_place = cfg_data_i;
        CFG_CORE_BUSY:  cfg_d.thr_clamp = cfg_data_i;
        CFG_MAIN_CORE:  cfg_d.home_core = cfg_data_i[CORE_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{thr_idle: 7'd20, thr_place: 7'd80, thr_clamp: 7'd95, home_core: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  clp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .valid_o (fe_valid),
    .item_o  (fe_item),
    .pop_i   (fe_pop)
  );

  clp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (fe_valid),
    .item_i  (fe_item),
    .pop_o   (fe_pop),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule
